// File: design/kvrph_pkg.sv
package kvrph_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned QID_W    = 16;
    localparam int unsigned KEYLEN_W = 16;
    localparam int unsigned HASH_W   = 32;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned OFF_W    = 17;

    // Multiplier of the polynomial key hash.
    localparam logic [HASH_W-1:0] HASH_MULT = 32'd1000000007;

    // Header layout: offsets of the bytes that are kept.
    localparam logic [OFF_W-1:0] OFF_QID_LO    = 17'd0;
    localparam logic [OFF_W-1:0] OFF_QID_HI    = 17'd1;
    localparam logic [OFF_W-1:0] OFF_KEYLEN_LO = 17'd4;
    localparam logic [OFF_W-1:0] OFF_KEYLEN_HI = 17'd5;
    localparam logic [OFF_W-1:0] HEADER_BYTES  = 17'd8;
    localparam logic [OFF_W-1:0] OFFSET_MAX    = {OFF_W{1'b1}};

    // Byte positions inside the little-endian value.
    localparam logic [1:0] VAL_B0 = 2'd0;
    localparam logic [1:0] VAL_B1 = 2'd1;
    localparam logic [1:0] VAL_B2 = 2'd2;
    localparam logic [1:0] VAL_B3 = 2'd3;

endpackage

// File: design/kvrph_byte_if.sv
interface kvrph_byte_if;

    logic                           valid;
    logic                           ready;
    logic [kvrph_pkg::BYTE_W-1:0]   data_byte;
    logic                           first_byte;
    logic                           last_byte;

    modport source (output valid, output data_byte, output first_byte, output last_byte,
                    input ready);
    modport sink   (input valid, input data_byte, input first_byte, input last_byte,
                    output ready);

endinterface

// File: design/kvrph_result_if.sv
interface kvrph_result_if;

    logic                                  valid;
    logic                                  ready;
    logic        [kvrph_pkg::QID_W-1:0]    query_id;
    logic        [kvrph_pkg::HASH_W-1:0]   key_hash;
    logic signed [kvrph_pkg::VALUE_W-1:0]  item_value;
    logic                                  truncated;

    modport source (output valid, output query_id, output key_hash, output item_value,
                    output truncated, input ready);
    modport sink   (input valid, input query_id, input key_hash, input item_value,
                    input truncated, output ready);

endinterface

// File: design/key_value_record_parser_hasher.sv
// Channel   Direction  Content
// payload   in         one payload word: data_byte, first_byte, last_byte
// result    out        query_id, key_hash, item_value, truncated
//
// A word is registered on acceptance and parsed from that register. Any
// result it causes is loaded into the result register when the parse stage
// advances, so a result passes the input register and then the result register.
// One word is accepted per cycle while payload ready is high; the parse
// stage is a single constant multiply and add plus the offset compares
// against the key end.
// Reset clears the parse state and leaves the block idle until a first byte.
// A stalled result holds the parse stage, and payload ready falls only while
// both the parse stage and the result register are occupied.
module key_value_record_parser_hasher
(
    input  logic                  clk,
    input  logic                  rst_n,
    kvrph_byte_if.sink            payload,
    kvrph_result_if.source        result
);
    import kvrph_pkg::*;

    // Input register stage.
    logic                  s1_valid_reg;
    logic [BYTE_W-1:0]     s1_byte_reg;
    logic                  s1_first_reg;
    logic                  s1_last_reg;

    // Parse state.
    logic [OFF_W-1:0]      offset_reg, offset_next;
    logic [QID_W-1:0]      qid_reg, qid_next;
    logic [KEYLEN_W-1:0]   keylen_reg, keylen_next;
    logic [HASH_W-1:0]     hash_reg, hash_next;
    logic [VALUE_W-1:0]    value_reg, value_next;
    logic                  done_reg, done_next;

    // Result register.
    logic                  out_valid_reg;
    logic [QID_W-1:0]      out_qid_reg;
    logic [HASH_W-1:0]     out_hash_reg;
    logic [VALUE_W-1:0]    out_value_reg;
    logic                  out_trunc_reg;

    logic                  s1_adv;
    logic                  s1_fire;
    logic                  in_fire;

    // State as seen by this word once a first byte has cleared it.
    logic [OFF_W-1:0]      off_eff;
    logic [QID_W-1:0]      qid_eff;
    logic [KEYLEN_W-1:0]   keylen_eff;
    logic [HASH_W-1:0]     hash_eff;
    logic [VALUE_W-1:0]    value_eff;
    logic                  done_eff;

    logic [OFF_W-1:0]      key_end;
    logic [OFF_W:0]        key_diff;
    logic                  in_key;
    logic                  in_value;
    logic [HASH_W-1:0]     hash_sx;
    logic [HASH_W-1:0]     hash_mul;
    logic                  emit;
    logic                  emit_trunc;

    // The parse stage moves on whenever the result register is free or drains.
    assign s1_adv        = !out_valid_reg || result.ready;
    assign s1_fire       = s1_valid_reg && s1_adv;
    assign payload.ready = !s1_valid_reg || s1_adv;
    assign in_fire       = payload.valid && payload.ready;

    assign off_eff    = s1_first_reg ? '0 : offset_reg;
    assign qid_eff    = s1_first_reg ? '0 : qid_reg;
    assign keylen_eff = s1_first_reg ? '0 : keylen_reg;
    assign hash_eff   = s1_first_reg ? '0 : hash_reg;
    assign value_eff  = s1_first_reg ? '0 : value_reg;
    assign done_eff   = s1_first_reg ? 1'b0 : done_reg;

    // Key occupies [8, key_end) and the value [key_end, key_end + 4).
    assign key_end  = HEADER_BYTES + {{(OFF_W-KEYLEN_W){1'b0}}, keylen_eff};
    assign key_diff = {1'b0, off_eff} - {1'b0, key_end};
    assign in_key   = (off_eff >= HEADER_BYTES) && key_diff[OFF_W];
    assign in_value = !key_diff[OFF_W] && (key_diff[OFF_W-1:2] == '0);

    assign hash_sx  = {{(HASH_W-BYTE_W){s1_byte_reg[BYTE_W-1]}}, s1_byte_reg};
    assign hash_mul = hash_eff * HASH_MULT;

    always_comb
    begin
        qid_next    = qid_eff;
        keylen_next = keylen_eff;
        hash_next   = hash_eff;
        value_next  = value_eff;
        done_next   = done_eff;
        offset_next = off_eff;
        emit        = 1'b0;
        emit_trunc  = 1'b0;

        if (!done_eff)
        begin
            if (off_eff == OFF_QID_LO)
            begin
                qid_next[7:0] = s1_byte_reg;
            end
            else if (off_eff == OFF_QID_HI)
            begin
                qid_next[15:8] = s1_byte_reg;
            end
            else if (off_eff == OFF_KEYLEN_LO)
            begin
                keylen_next[7:0] = s1_byte_reg;
            end
            else if (off_eff == OFF_KEYLEN_HI)
            begin
                keylen_next[15:8] = s1_byte_reg;
            end
            else if (in_key)
            begin
                hash_next = hash_mul + hash_sx;
            end
            else if (in_value)
            begin
                case (key_diff[1:0])
                    VAL_B0:  value_next[7:0]   = s1_byte_reg;
                    VAL_B1:  value_next[15:8]  = s1_byte_reg;
                    VAL_B2:  value_next[23:16] = s1_byte_reg;
                    VAL_B3:  value_next[31:24] = s1_byte_reg;
                    default: value_next        = value_eff;
                endcase
            end

            if (off_eff != OFFSET_MAX)
            begin
                offset_next = off_eff + 1'b1;
            end

            // The final value byte completes the record, even when it is also
            // the last byte of the payload.
            if (in_value && (key_diff[1:0] == VAL_B3))
            begin
                done_next = 1'b1;
                emit      = 1'b1;
            end
            else if (s1_last_reg)
            begin
                done_next  = 1'b1;
                emit       = 1'b1;
                emit_trunc = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            offset_reg    <= '0;
            qid_reg       <= '0;
            keylen_reg    <= '0;
            hash_reg      <= '0;
            value_reg     <= '0;
            done_reg      <= 1'b1;
        end
        else
        begin
            if (payload.ready)
            begin
                s1_valid_reg <= payload.valid;
            end

            if (s1_fire)
            begin
                offset_reg <= offset_next;
                qid_reg    <= qid_next;
                keylen_reg <= keylen_next;
                hash_reg   <= hash_next;
                value_reg  <= value_next;
                done_reg   <= done_next;
            end

            if (s1_adv)
            begin
                out_valid_reg <= s1_valid_reg && emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_byte_reg  <= payload.data_byte;
            s1_first_reg <= payload.first_byte;
            s1_last_reg  <= payload.last_byte;
        end

        if (s1_fire && emit)
        begin
            out_qid_reg   <= qid_next;
            out_hash_reg  <= hash_next;
            out_value_reg <= value_next;
            out_trunc_reg <= emit_trunc;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.query_id   = out_qid_reg;
    assign result.key_hash   = out_hash_reg;
    assign result.item_value = out_value_reg;
    assign result.truncated  = out_trunc_reg;

`ifndef SYNTHESIS
    // A result produced by the parse stage must appear in the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && emit) |=> out_valid_reg)
        else $error("parsed result not registered");

    // After any emitted result the parser goes idle until the next first byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && emit) |=> done_reg)
        else $error("parser not idle after result");

    // A truncated result only comes from the last byte of a payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && emit_trunc) |-> s1_last_reg)
        else $error("truncated result without last byte");

    // An idle parser never emits unless the word starts a new payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && done_reg && !s1_first_reg) |-> !emit)
        else $error("result emitted while idle");
`endif

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

    import kvrph_pkg::*;

    // One payload word as it crosses the input channel.
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              first_byte;
        logic              last_byte;
    } pay_word_t;

    // One parsed record as it leaves the result channel.
    typedef struct packed {
        logic        [QID_W-1:0]   query_id;
        logic        [HASH_W-1:0]  key_hash;
        logic signed [VALUE_W-1:0] item_value;
        logic                      truncated;
    } kv_record_t;

    // Counted words per random phase; ignored words do not count.
    localparam int unsigned WORDS_PER_PHASE = 180;
    localparam int unsigned MAX_REPORTS     = 10;

    logic clk;
    logic rst_n;

    kvrph_byte_if   payload_ch ();
    kvrph_result_if result_ch ();

    key_value_record_parser_hasher u_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .payload (payload_ch),
        .result  (result_ch)
    );

    // Words waiting to be offered, and records the parser should produce.
    pay_word_t  word_q[$];
    kv_record_t record_q[$];

    // Percentages of cycles in which the sender idles and the receiver stalls.
    int unsigned send_idle_pct;
    int unsigned stall_pct;
    int unsigned mismatches;

    // Shadow copy of the parser state, advanced once per accepted word.
    logic [OFF_W-1:0]    parse_offset;
    logic [QID_W-1:0]    parse_qid;
    logic [KEYLEN_W-1:0] parse_keylen;
    logic [HASH_W-1:0]   parse_hash;
    logic [VALUE_W-1:0]  parse_value;
    logic                parse_done;

    // The clock runs with a 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Advance the shadow parser by one accepted word. Returns 1 when the word
    // completes a record, either by its last value byte or by an early end.
    function automatic bit parse_word(input pay_word_t w, output kv_record_t rec);
        int unsigned key_end;
        int unsigned idx;
        rec = '0;
        // A first byte restarts parsing from any state, even mid-record.
        if (w.first_byte)
        begin
            parse_offset = '0;
            parse_qid    = '0;
            parse_keylen = '0;
            parse_hash   = '0;
            parse_value  = '0;
            parse_done   = 1'b0;
        end
        // Between records every word is dropped, last_byte included.
        if (parse_done)
            return 1'b0;

        key_end = HEADER_BYTES + parse_keylen;

        if (parse_offset == OFF_QID_LO)
            parse_qid[7:0] = w.data_byte;
        else if (parse_offset == OFF_QID_HI)
            parse_qid[15:8] = w.data_byte;
        else if (parse_offset == OFF_KEYLEN_LO)
            parse_keylen[7:0] = w.data_byte;
        else if (parse_offset == OFF_KEYLEN_HI)
            parse_keylen[15:8] = w.data_byte;
        else if (parse_offset >= HEADER_BYTES && parse_offset < key_end)
        begin
            // Key bytes enter the hash sign-extended.
            parse_hash = parse_hash * HASH_MULT
                       + {{(HASH_W-BYTE_W){w.data_byte[BYTE_W-1]}}, w.data_byte};
        end
        else if (parse_offset >= key_end && parse_offset < key_end + 4)
        begin
            idx = parse_offset - key_end;
            parse_value[idx*8 +: 8] = w.data_byte;
            if (idx == VAL_B3)
            begin
                // The value is complete; a last_byte on this word adds nothing.
                parse_done = 1'b1;
                rec = '{parse_qid, parse_hash, parse_value, 1'b0};
                if (parse_offset != OFFSET_MAX)
                    parse_offset++;
                return 1'b1;
            end
        end

        if (parse_offset != OFFSET_MAX)
            parse_offset++;

        // The payload ended before the value was complete.
        if (w.last_byte)
        begin
            parse_done = 1'b1;
            rec = '{parse_qid, parse_hash, parse_value, 1'b1};
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Queue a run of bytes as words, optionally opening and closing a payload.
    task automatic queue_payload(input logic [BYTE_W-1:0] bytes[$], input bit opens,
                                 input bit closes);
        pay_word_t w;
        for (int i = 0; i < bytes.size(); i++)
        begin
            w.data_byte  = bytes[i];
            w.first_byte = opens && (i == 0);
            w.last_byte  = closes && (i == bytes.size() - 1);
            word_q.push_back(w);
        end
    endtask

    // Queue one random payload. A well-formed one carries a full header, key
    // and value, possibly followed by trailing bytes. A broken one is cut at a
    // random length and either closed there or left open for the next first byte.
    task automatic queue_random_record(input bit broken, output int unsigned counted);
        logic [BYTE_W-1:0]   bytes[$];
        logic [KEYLEN_W-1:0] klen;
        int unsigned         roll;
        int unsigned         nkey;
        int unsigned         cut;
        roll = $urandom_range(0, 29);
        if (roll == 0)
            klen = KEYLEN_W'(256 + $urandom_range(0, 24));
        else if (broken && roll < 12)
            klen = KEYLEN_W'($urandom);
        else
            klen = KEYLEN_W'($urandom_range(0, 12));
        // Broken payloads with huge key lengths only need a few key bytes.
        nkey = (roll != 0 && klen > 24) ? 24 : klen;

        bytes = {};
        repeat (4) bytes.push_back(BYTE_W'($urandom));
        bytes.push_back(klen[7:0]);
        bytes.push_back(klen[15:8]);
        repeat (2) bytes.push_back(BYTE_W'($urandom));
        repeat (nkey) bytes.push_back(BYTE_W'($urandom));
        repeat (4) bytes.push_back(BYTE_W'($urandom));

        if (broken)
        begin
            cut = $urandom_range(1, bytes.size());
            while (bytes.size() > cut)
                void'(bytes.pop_back());
            counted = cut;
            queue_payload(bytes, 1'b1, $urandom_range(0, 2) != 0);
        end
        else
        begin
            counted = bytes.size();
            // With no trailing bytes the last value byte also ends the payload.
            repeat ($urandom_range(0, 3)) bytes.push_back(BYTE_W'($urandom));
            queue_payload(bytes, 1'b1, 1'b1);
        end
    endtask

    // Driver: offers the next queued word unless the sender idles this cycle,
    // holds a word until it is taken, and predicts the parser's output for
    // every word that is taken.
    always @(posedge clk or negedge rst_n)
    begin : drive_words
        pay_word_t  cur;
        pay_word_t  nxt;
        kv_record_t rec;
        if (!rst_n)
        begin
            payload_ch.valid      <= 1'b0;
            payload_ch.data_byte  <= '0;
            payload_ch.first_byte <= 1'b0;
            payload_ch.last_byte  <= 1'b0;
        end
        else
        begin
            if (payload_ch.valid && payload_ch.ready)
            begin
                cur.data_byte  = payload_ch.data_byte;
                cur.first_byte = payload_ch.first_byte;
                cur.last_byte  = payload_ch.last_byte;
                if (parse_word(cur, rec))
                    record_q.push_back(rec);
            end
            if (!payload_ch.valid || payload_ch.ready)
            begin
                if (word_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    nxt = word_q.pop_front();
                    payload_ch.valid      <= 1'b1;
                    payload_ch.data_byte  <= nxt.data_byte;
                    payload_ch.first_byte <= nxt.first_byte;
                    payload_ch.last_byte  <= nxt.last_byte;
                end
                else
                begin
                    payload_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: takes records under a random stall and compares each one with
    // the oldest predicted record.
    always @(posedge clk or negedge rst_n)
    begin : check_records
        kv_record_t got;
        kv_record_t want;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                got = '{result_ch.query_id, result_ch.key_hash, result_ch.item_value,
                        result_ch.truncated};
                if (record_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: unexpected record qid=%h hash=%h value=%h trunc=%b",
                                 $realtime, got.query_id, got.key_hash, got.item_value,
                                 got.truncated);
                end
                else
                begin
                    want = record_q.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"%0t: record mismatch expected qid=%h hash=%h ",
                                      "value=%h trunc=%b, got qid=%h hash=%h value=%h trunc=%b"},
                                     $realtime, want.query_id, want.key_hash,
                                     want.item_value, want.truncated, got.query_id,
                                     got.key_hash, got.item_value, got.truncated);
                    end
                end
            end
            result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Stimulus and end of run.
    initial
    begin : run_stimulus
        logic [BYTE_W-1:0] bytes[$];
        int unsigned       counted;
        int unsigned       added;
        clk                   = 1'b0;
        rst_n                 = 1'b0;
        payload_ch.valid      = 1'b0;
        payload_ch.data_byte  = '0;
        payload_ch.first_byte = 1'b0;
        payload_ch.last_byte  = 1'b0;
        result_ch.ready       = 1'b0;
        send_idle_pct         = 0;
        stall_pct             = 0;
        mismatches            = 0;

        // After reset the parser is idle until it sees a first byte.
        parse_offset = '0;
        parse_qid    = '0;
        parse_keylen = '0;
        parse_hash   = '0;
        parse_value  = '0;
        parse_done   = 1'b1;

        // Words before any first byte are dropped, even one marked last.
        bytes = '{8'h5A, 8'hC3};
        queue_payload(bytes, 1'b0, 1'b1);
        // Empty key, all-ones query id, most negative value, and the last
        // value byte doubling as the end of the payload.
        bytes = '{8'hFF, 8'hFF, 8'h0C, 8'h00, 8'h00, 8'h00, 8'h04, 8'h00,
                  8'h00, 8'h00, 8'h00, 8'h80};
        queue_payload(bytes, 1'b1, 1'b1);
        // A stray word after a finished record is dropped.
        bytes = '{8'h11};
        queue_payload(bytes, 1'b0, 1'b1);
        // A payload of a single word that is both first and last.
        bytes = '{8'hAB};
        queue_payload(bytes, 1'b1, 1'b1);
        // Largest key length, cut short inside the key: the hash covers only
        // the key bytes seen, including sign-extended ones.
        bytes = '{8'h34, 8'h12, 8'h0E, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00,
                  8'h80, 8'hFF};
        queue_payload(bytes, 1'b1, 1'b1);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Four phases: no idling, a slow sender, a slow receiver, and both.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 81; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 81; end
                default: begin send_idle_pct = 30; stall_pct = 30; end
            endcase
            counted = 0;
            while (counted < WORDS_PER_PHASE)
            begin
                queue_random_record($urandom_range(0, 4) == 0, added);
                counted += added;
                // Now and then stray words without a first byte follow.
                if ($urandom_range(0, 9) == 0)
                begin
                    bytes = {};
                    repeat ($urandom_range(1, 3)) bytes.push_back(BYTE_W'($urandom));
                    queue_payload(bytes, 1'b0, $urandom_range(0, 1) != 0);
                end
            end
            while (word_q.size() != 0)
                @(posedge clk);
        end

        // Drain: every word taken, every predicted record received, then a
        // few more cycles to catch any record that should not appear.
        send_idle_pct = 0;
        stall_pct     = 0;
        do
            @(posedge clk);
        while (payload_ch.valid || word_q.size() != 0);
        while (record_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial
    begin
        #1000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
